// ===== rtl/mcrpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Masked color range pixel counter package
// Shared constants, register indexes and types for the pixel counter.
// ----------------------------------------------------------------------------
package mcrpc_pkg;

    localparam int WINDOW_PIXELS = 100;
    localparam int BOX_COUNT     = 3;

    localparam int POS_W    = 7;
    localparam int COUNT_W  = 7;
    localparam int THR_W    = 8;
    localparam int EN_W     = 2;
    localparam int BOX_W    = 48;
    localparam int MASK_W   = 64;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int BOX_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [POS_W-1:0]   POSITION_MAX = '1;
    localparam logic [POS_W-1:0]   WINDOW_LAST  = POS_W'(WINDOW_PIXELS - 1);
    localparam logic [THR_W-1:0]   THR_RESET    = 8'd100;
    localparam logic [EN_W-1:0]    BOX_LIMIT    = EN_W'(BOX_COUNT);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MASK_LOW      = 3'd0,
        REG_MASK_HIGH     = 3'd1,
        REG_BOX_ZERO      = 3'd2,
        REG_BOX_ONE       = 3'd3,
        REG_BOX_TWO       = 3'd4,
        REG_BOXES_ENABLED = 3'd5,
        REG_HIT_THRESHOLD = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] blue_max;
        logic [7:0] blue_min;
        logic [7:0] green_max;
        logic [7:0] green_min;
        logic [7:0] red_max;
        logic [7:0] red_min;
    } color_box_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic advance;
        logic counted;
        logic clear;
    } count_ctrl_t;

endpackage

// ===== rtl/mcrpc_box_counter.sv =====
// ----------------------------------------------------------------------------
// Color box match counter
// Tests one pixel against an inclusive RGB box and keeps a saturating count.
// ----------------------------------------------------------------------------
module mcrpc_box_counter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mcrpc_pkg::color_box_t         box,
    input  mcrpc_pkg::pixel_t             pixel,
    input  mcrpc_pkg::count_ctrl_t        ctrl,
    output logic [mcrpc_pkg::COUNT_W-1:0] count_upd
);
    import mcrpc_pkg::*;

    logic               match;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign match = (pixel.red   >= box.red_min)   && (pixel.red   <= box.red_max)   &&
                   (pixel.green >= box.green_min) && (pixel.green <= box.green_max) &&
                   (pixel.blue  >= box.blue_min)  && (pixel.blue  <= box.blue_max);

    always_comb
    begin
        count_upd = count_reg;
        if (ctrl.counted && match && (count_reg != COUNT_MAX))
        begin
            count_upd = count_reg + COUNT_W'(1);
        end
        count_next = count_reg;
        if (ctrl.advance)
        begin
            count_next = ctrl.clear ? '0 : count_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/masked_color_range_pixel_counter.sv =====
// ----------------------------------------------------------------------------
// Masked color range pixel counter
// Counts masked window pixels that fall in up to three RGB boxes and reports
// a hit at the end of each window.
// ----------------------------------------------------------------------------
// Pixels enter on the in channel (red, green, blue, frame_end) in raster
// order, one request per pixel, and frame_end marks the last pixel of a
// window. Only a frame_end pixel produces a request on the out channel,
// carrying hit and hit_box.
// A pixel is captured in an input register, and from there it updates the
// position counter and the three box counters when it advances; a frame_end
// pixel loads the result register at that same edge. One pixel is accepted
// every cycle while no frame_end pixel waits for a busy result register.
// When the receiver stalls with a result pending, a further frame_end pixel
// waits in the input register and the input stalls behind it; ordinary
// pixels keep flowing while the result waits.
// Reset clears the counters, the pipeline and the configuration registers
// (hit_threshold resets to 100). Configuration is written on the cfg port and
// takes effect for pixels processed after the write.
// ----------------------------------------------------------------------------
module masked_color_range_pixel_counter
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mcrpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mcrpc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      red,
    input  logic [7:0]                      green,
    input  logic [7:0]                      blue,
    input  logic                            frame_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            hit,
    output logic [mcrpc_pkg::BOX_IDX_W-1:0] hit_box
);
    import mcrpc_pkg::*;

    logic [MASK_W-1:0] mask_low_reg;
    logic [MASK_W-1:0] mask_high_reg;
    color_box_t        box_reg [BOX_COUNT];
    logic [EN_W-1:0]   enabled_reg;
    logic [THR_W-1:0]  threshold_reg;

    logic              pix_valid_reg;
    pixel_t            pix_reg;
    logic              pix_last_reg;

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              done_reg;
    logic              done_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 hit_reg;
    logic [BOX_IDX_W-1:0] hit_box_reg;
    logic                 hit_next;
    logic [BOX_IDX_W-1:0] hit_box_next;

    logic               out_free;
    logic               advance;
    logic               mask_bit;
    logic [THR_W-1:0]   thr_eff;
    logic [EN_W-1:0]    used;
    count_ctrl_t        ctrl;
    logic [COUNT_W-1:0] count_upd [BOX_COUNT];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_low_reg  <= '0;
            mask_high_reg <= '0;
            for (int b = 0; b < BOX_COUNT; b++)
            begin
                box_reg[b] <= '0;
            end
            enabled_reg   <= '0;
            threshold_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MASK_LOW:      mask_low_reg  <= cfg_data;
                REG_MASK_HIGH:     mask_high_reg <= cfg_data;
                REG_BOX_ZERO:      box_reg[0]    <= cfg_data[BOX_W-1:0];
                REG_BOX_ONE:
                begin
                    if (BOX_COUNT > 1)
                    begin
                        box_reg[1 % BOX_COUNT] <= cfg_data[BOX_W-1:0];
                    end
                end
                REG_BOX_TWO:
                begin
                    if (BOX_COUNT > 2)
                    begin
                        box_reg[2 % BOX_COUNT] <= cfg_data[BOX_W-1:0];
                    end
                end
                REG_BOXES_ENABLED: enabled_reg   <= cfg_data[EN_W-1:0];
                REG_HIT_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Handshake: a frame_end pixel needs a free result register.
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = pix_valid_reg && (!pix_last_reg || out_free);
    assign in_ready = !pix_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            pix_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pix_reg      <= '{red: red, green: green, blue: blue};
            pix_last_reg <= frame_end;
        end
    end

    // Window position and mask lookup.
    assign mask_bit = (pos_reg[POS_W-1] == 1'b0) ? mask_low_reg[pos_reg[POS_W-2:0]]
                                                 : mask_high_reg[pos_reg[POS_W-2:0]];

    assign ctrl.advance = advance;
    assign ctrl.counted = !done_reg && mask_bit;
    assign ctrl.clear   = pix_last_reg;

    always_comb
    begin
        pos_next  = pos_reg;
        done_next = done_reg;
        if (advance)
        begin
            if (!done_reg)
            begin
                if ((pos_reg >= WINDOW_LAST) || (pos_reg == POSITION_MAX))
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            if (pix_last_reg)
            begin
                pos_next  = '0;
                done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
    end

    for (genvar b = 0; b < BOX_COUNT; b++)
    begin : g_box
        mcrpc_box_counter u_box
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .box       (box_reg[b]),
            .pixel     (pix_reg),
            .ctrl      (ctrl),
            .count_upd (count_upd[b])
        );
    end

    // Hit decision on the updated counts.
    assign thr_eff = (threshold_reg == '0) ? THR_W'(1) : threshold_reg;
    assign used    = (enabled_reg > BOX_LIMIT) ? BOX_LIMIT : enabled_reg;

    always_comb
    begin
        hit_next     = 1'b0;
        hit_box_next = '0;
        for (int b = BOX_COUNT - 1; b >= 0; b--)
        begin
            if ((EN_W'(b) < used) && ({1'b0, count_upd[b]} >= thr_eff))
            begin
                hit_next     = 1'b1;
                hit_box_next = BOX_IDX_W'(b);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && pix_last_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pix_last_reg)
        begin
            hit_reg     <= hit_next;
            hit_box_reg <= hit_box_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_box   = hit_box_reg;

`ifndef ASSERT_OFF
    // The reported box is always one of the built boxes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit_box < BOX_IDX_W'(BOX_COUNT)))
        else $error("hit_box names a box that does not exist");

    // A miss always reports box zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (hit_box == '0))
        else $error("hit_box is not zero on a miss");

    // The position counter never runs past the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= WINDOW_LAST)
        else $error("pixel position beyond the window");

    // A processed frame_end pixel always leaves a pending result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && pix_last_reg) |=> out_valid)
        else $error("frame end pixel produced no result");
`endif

endmodule

// ===== dv/pixel_count_checker.sv =====
// ----------------------------------------------------------------------------
// Pixel counter scoreboard
// Watches the configuration port and both request channels of the masked
// color range pixel counter, keeps its own copy of the registers and window
// counters, predicts the window verdict of every frame_end pixel and compares
// each returned verdict with the oldest prediction.
// ----------------------------------------------------------------------------
module pixel_count_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mcrpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mcrpc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [7:0]                      red,
    input  logic [7:0]                      green,
    input  logic [7:0]                      blue,
    input  logic                            frame_end,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            hit,
    input  logic [mcrpc_pkg::BOX_IDX_W-1:0] hit_box,
    output int unsigned                     mismatches,
    output int unsigned                     pending
);

    import mcrpc_pkg::*;

    typedef struct packed {
        logic                 hit;
        logic [BOX_IDX_W-1:0] hit_box;
    } verdict_t;

    logic [2*MASK_W-1:0] mask_bits;
    color_box_t          boxes [BOX_COUNT];
    logic [EN_W-1:0]     boxes_used;
    logic [THR_W-1:0]    threshold;
    logic [POS_W-1:0]    position;
    logic                window_full;
    logic [COUNT_W-1:0]  match_count [BOX_COUNT];
    verdict_t            window_verdicts [$];

    initial mismatches = 0;

    function automatic logic box_contains(color_box_t bx, logic [7:0] r, logic [7:0] g,
                                          logic [7:0] b);
        return r >= bx.red_min && r <= bx.red_max &&
               g >= bx.green_min && g <= bx.green_max &&
               b >= bx.blue_min && b <= bx.blue_max;
    endfunction

    function automatic void clear_window();
        position    = '0;
        window_full = 1'b0;
        for (int i = 0; i < BOX_COUNT; i++)
            match_count[i] = '0;
    endfunction

    function automatic void count_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic last);
        logic [THR_W-1:0] need;
        int               used;
        verdict_t         v;
        if (!window_full && position < WINDOW_PIXELS && mask_bits[position])
        begin
            for (int i = 0; i < BOX_COUNT; i++)
                if (box_contains(boxes[i], r, g, b) && match_count[i] != COUNT_MAX)
                    match_count[i] = match_count[i] + 1'b1;
        end
        if (!window_full)
        begin
            if (int'(position) + 1 >= WINDOW_PIXELS || position == POSITION_MAX)
                window_full = 1'b1;
            else
                position = position + 1'b1;
        end
        if (last)
        begin
            need = (threshold == '0) ? THR_W'(1) : threshold;
            used = (int'(boxes_used) > BOX_COUNT) ? BOX_COUNT : int'(boxes_used);
            v    = '0;
            for (int i = used - 1; i >= 0; i--)
                if ({1'b0, match_count[i]} >= need)
                begin
                    v.hit     = 1'b1;
                    v.hit_box = BOX_IDX_W'(i);
                end
            window_verdicts.push_back(v);
            clear_window();
        end
    endfunction

    function automatic void note_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            mask_bits  = '0;
            boxes_used = '0;
            threshold  = THR_RESET;
            for (int i = 0; i < BOX_COUNT; i++)
                boxes[i] = '0;
            clear_window();
            window_verdicts.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_MASK_LOW:      mask_bits[MASK_W-1:0]        = cfg_data[MASK_W-1:0];
                    REG_MASK_HIGH:     mask_bits[2*MASK_W-1:MASK_W] = cfg_data[MASK_W-1:0];
                    REG_BOX_ZERO:      boxes[0]   = cfg_data[BOX_W-1:0];
                    REG_BOX_ONE:       boxes[1]   = cfg_data[BOX_W-1:0];
                    REG_BOX_TWO:       boxes[2]   = cfg_data[BOX_W-1:0];
                    REG_BOXES_ENABLED: boxes_used = cfg_data[EN_W-1:0];
                    REG_HIT_THRESHOLD: threshold  = cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                count_pixel(red, green, blue, frame_end);
            if (out_valid && out_ready)
            begin
                if (window_verdicts.size() == 0)
                    note_failure($sformatf("unexpected verdict hit=%0d hit_box=%0d",
                                           hit, hit_box));
                else
                begin
                    want = window_verdicts.pop_front();
                    if (want.hit !== hit)
                        note_failure($sformatf("hit expected %0d actual %0d", want.hit, hit));
                    if (want.hit_box !== hit_box)
                        note_failure($sformatf("hit_box expected %0d actual %0d",
                                               want.hit_box, hit_box));
                end
            end
            pending <= window_verdicts.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Masked color range pixel counter testbench
// Programs masks, color boxes, box count and threshold between phases, sends
// directed and random pixel windows with random idle gaps on both channels,
// and lets the scoreboard check every window verdict.
// ----------------------------------------------------------------------------
module tb_top;

    import mcrpc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 3'd7;
    localparam color_box_t           FULL_BOX      = 48'hFF00_FF00_FF00;
    localparam color_box_t           EMPTY_BOX     = 48'h00FF_00FF_00FF;
    localparam int unsigned          RANDOM_PIXELS = 1600;
    localparam int unsigned          SETTLE_CYCLES = 6;
    localparam int unsigned          STALL_LIMIT   = 2000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [7:0]           red       = '0;
    logic [7:0]           green     = '0;
    logic [7:0]           blue      = '0;
    logic                 frame_end = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 hit;
    logic [BOX_IDX_W-1:0] hit_box;

    int unsigned mismatches;
    int unsigned pending;

    logic [MASK_W-1:0] mask_lo;
    logic [MASK_W-1:0] mask_hi;
    color_box_t        box_val [BOX_COUNT];
    logic [EN_W-1:0]   used_val;
    logic [THR_W-1:0]  thr_val;

    bit          steady      = 1'b0;
    int unsigned ready_hold  = 0;
    int unsigned quiet       = 0;
    int unsigned pixels_sent = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    masked_color_range_pixel_counter u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .frame_end (frame_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .hit_box   (hit_box)
    );

    pixel_count_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .hit_box    (hit_box),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        int unsigned stall;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_hold <= 0;
        end
        else if (steady)
        begin
            out_ready  <= 1'b1;
            ready_hold <= 0;
        end
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (out_ready)
        begin
            stall = idle_len();
            if (stall != 0)
            begin
                out_ready  <= 1'b0;
                ready_hold <= stall - 1;
            end
            else
                ready_hold <= $urandom_range(0, 6);
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else if (quiet + 1 >= STALL_LIMIT)
        begin
            $display("FAIL masked_color_range_pixel_counter");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic put_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic last);
        int unsigned gap;
        gap = steady ? 0 : idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        red       <= r;
        green     <= g;
        blue      <= b;
        frame_end <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic apply_config();
        write_reg(REG_MASK_LOW, mask_lo);
        write_reg(REG_MASK_HIGH, mask_hi);
        write_reg(REG_BOX_ZERO, {16'($urandom), box_val[0]});
        write_reg(REG_BOX_ONE, {16'($urandom), box_val[1]});
        write_reg(REG_BOX_TWO, {16'($urandom), box_val[2]});
        write_reg(REG_BOXES_ENABLED, {$urandom, 30'($urandom), used_val});
        write_reg(REG_HIT_THRESHOLD, {$urandom, 24'($urandom), thr_val});
        if ($urandom_range(0, 1) == 1)
            write_reg(REG_UNUSED, {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic color_box_t point_box(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        return '{blue_max: b, blue_min: b, green_max: g, green_min: g, red_max: r, red_min: r};
    endfunction

    function automatic color_box_t random_box();
        logic [7:0]  lo [3];
        logic [7:0]  hi [3];
        int unsigned mode;
        int unsigned j;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++)
        begin
            if (mode == 0)
            begin
                lo[k] = 8'd0;
                hi[k] = 8'd255;
            end
            else
            begin
                lo[k] = 8'($urandom_range(0, 255));
                hi[k] = 8'($urandom_range(lo[k], 255));
            end
        end
        if (mode == 1)
        begin
            j     = $urandom_range(0, 2);
            lo[j] = 8'd255;
            hi[j] = 8'd0;
        end
        return '{blue_max: hi[2], blue_min: lo[2], green_max: hi[1], green_min: lo[1],
                 red_max: hi[0], red_min: lo[0]};
    endfunction

    function automatic logic [MASK_W-1:0] random_mask();
        case ($urandom_range(0, 5))
            0:       return '1;
            1:       return '0;
            2:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            3:       return {$urandom, $urandom} | {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic pixel_t pick_pixel();
        pixel_t     px;
        color_box_t bx;
        logic [7:0] lo [3];
        logic [7:0] hi [3];
        logic [7:0] c  [3];
        px = pixel_t'(24'($urandom));
        if ($urandom_range(0, 9) < 7)
        begin
            bx = box_val[$urandom_range(0, BOX_COUNT - 1)];
            lo = '{bx.red_min, bx.green_min, bx.blue_min};
            hi = '{bx.red_max, bx.green_max, bx.blue_max};
            for (int k = 0; k < 3; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       c[k] = lo[k];
                    1:       c[k] = hi[k];
                    2:       c[k] = lo[k] - 8'd1;
                    3:       c[k] = hi[k] + 8'd1;
                    default: c[k] = (lo[k] <= hi[k]) ? 8'($urandom_range(lo[k], hi[k]))
                                                     : 8'($urandom);
                endcase
            end
            px = '{red: c[0], green: c[1], blue: c[2]};
        end
        return px;
    endfunction

    function automatic int unsigned window_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(1, 12);
        if (r < 55)
            return $urandom_range(13, 98);
        return $urandom_range(99, 130);
    endfunction

    initial
    begin
        int unsigned budget;
        int unsigned sent;
        int unsigned len;
        pixel_t      px;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        mask_lo    = '1;
        mask_hi    = '1;
        box_val[0] = FULL_BOX;
        box_val[1] = EMPTY_BOX;
        box_val[2] = point_box(8'd255, 8'd0, 8'd255);
        used_val   = 2'd3;
        thr_val    = 8'd0;
        apply_config();
        put_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        put_pixel(8'd255, 8'd0, 8'd255, 1'b1);
        put_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        put_pixel(8'd128, 8'd127, 8'd1, 1'b1);
        settle();

        mask_lo = '0;
        mask_hi = '0;
        thr_val = 8'd1;
        apply_config();
        put_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        settle();

        mask_lo    = '1;
        box_val[0] = EMPTY_BOX;
        box_val[1] = point_box(8'd0, 8'd255, 8'd0);
        thr_val    = 8'd2;
        apply_config();
        put_pixel(8'd255, 8'd0, 8'd255, 1'b0);
        put_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        put_pixel(8'd255, 8'd0, 8'd255, 1'b1);
        put_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        put_pixel(8'd0, 8'd255, 8'd0, 1'b1);
        settle();

        used_val = 2'd2;
        thr_val  = 8'd1;
        apply_config();
        put_pixel(8'd255, 8'd0, 8'd255, 1'b1);
        put_pixel(8'd0, 8'd255, 8'd0, 1'b1);
        settle();

        pixels_sent = 0;
        while (pixels_sent < RANDOM_PIXELS)
        begin
            mask_lo  = random_mask();
            mask_hi  = random_mask();
            for (int i = 0; i < BOX_COUNT; i++)
                box_val[i] = random_box();
            used_val = EN_W'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:       thr_val = 8'd0;
                1:       thr_val = 8'd1;
                2:       thr_val = 8'd127;
                3:       thr_val = 8'd128;
                4:       thr_val = 8'd100;
                default: thr_val = 8'($urandom_range(1, 40));
            endcase
            steady = ($urandom_range(0, 3) == 0);
            apply_config();
            budget = $urandom_range(80, 260);
            sent   = 0;
            while (sent < budget)
            begin
                len = window_len();
                for (int k = 0; k < len; k++)
                begin
                    px = pick_pixel();
                    put_pixel(px.red, px.green, px.blue, k == len - 1);
                end
                sent += len;
            end
            settle();
        end

        if (mismatches == 0 && pending == 0)
            $display("PASS masked_color_range_pixel_counter");
        else
            $display("FAIL masked_color_range_pixel_counter");
        $finish;
    end

endmodule
